// ===== rtl/isort_pkg.sv =====
// Shared constants and types for the insertion sorter.
package isort_pkg;

    localparam int CAPACITY    = 32;
    localparam int VALUE_BITS  = 20;
    localparam int COUNT_BITS  = $clog2(CAPACITY + 1);
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
    localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

    typedef logic [VALUE_BITS-1:0] value_t;

    typedef struct packed {
        value_t value;
        logic   batch_end;
    } item_t;

endpackage

// ===== rtl/insertion_sorter_top.sv =====
// Insertion sorter: a short input queue feeding a parallel insertion store with readout.
//
// Each item (value, batch_end) is taken when start is high and busy is low, and goes into a
// four-entry queue. While loading, the back end inserts one queued item per cycle into a
// store of 32 values that compares every cell at once; equal values keep arrival order.
// After the item marked batch_end, the back end emits the batch smallest first, one result
// per cycle on strobe, and final_result marks the last one. While it emits, items still
// enter the queue until it fills, and busy then holds them off. Results cannot be stalled
// by the receiver. Values beyond 32 in a batch are dropped and every result of that batch
// shows dropped.
module insertion_sorter_top (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  isort_pkg::value_t    value,
    input  logic                 batch_end,
    output logic                 busy,
    output logic                 strobe,
    output isort_pkg::value_t    sorted_value,
    output logic                 final_result,
    output logic                 dropped
);

    isort_pkg::item_t    item;
    logic                item_valid;
    logic                item_ready;

    isort_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .value      (value),
        .batch_end  (batch_end),
        .busy       (busy),
        .item_valid (item_valid),
        .item       (item),
        .item_ready (item_ready)
    );

    isort_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item         (item),
        .item_ready   (item_ready),
        .strobe       (strobe),
        .sorted_value (sorted_value),
        .final_result (final_result),
        .dropped      (dropped)
    );

endmodule

// ===== rtl/isort_front.sv =====
// Front end: accepts items and queues them for the sorting back end.
module isort_front (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  isort_pkg::value_t    value,
    input  logic                 batch_end,
    output logic                 busy,
    output logic                 item_valid,
    output isort_pkg::item_t     item,
    input  logic                 item_ready
);

    isort_pkg::item_t                   entries_reg [isort_pkg::QUEUE_DEPTH];
    logic [isort_pkg::QPTR_BITS-1:0]    wr_ptr_reg;
    logic [isort_pkg::QPTR_BITS-1:0]    wr_ptr_next;
    logic [isort_pkg::QPTR_BITS-1:0]    rd_ptr_reg;
    logic [isort_pkg::QPTR_BITS-1:0]    rd_ptr_next;
    logic [isort_pkg::QCNT_BITS-1:0]    fill_reg;
    logic [isort_pkg::QCNT_BITS-1:0]    fill_next;
    logic                               push;
    logic                               pop;

    assign busy       = (fill_reg == isort_pkg::QCNT_BITS'(isort_pkg::QUEUE_DEPTH));
    assign push       = start && !busy;
    assign item_valid = (fill_reg != '0);
    assign pop        = item_valid && item_ready;
    assign item       = entries_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        fill_next   = fill_reg;
        if (push && !pop)
        begin
            fill_next = fill_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entries_reg[wr_ptr_reg] <= '{value: value, batch_end: batch_end};
        end
    end

endmodule

// ===== rtl/isort_back.sv =====
// Back end: parallel insertion into the sorted store and batch readout.
module isort_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 item_valid,
    input  isort_pkg::item_t     item,
    output logic                 item_ready,
    output logic                 strobe,
    output isort_pkg::value_t    sorted_value,
    output logic                 final_result,
    output logic                 dropped
);

    typedef enum logic {
        ST_LOAD,
        ST_EMIT
    } state_t;

    state_t                              state_reg;
    state_t                              state_next;
    isort_pkg::value_t                   store_reg  [isort_pkg::CAPACITY];
    isort_pkg::value_t                   store_next [isort_pkg::CAPACITY];
    logic [isort_pkg::COUNT_BITS-1:0]    held_reg;
    logic [isort_pkg::COUNT_BITS-1:0]    held_next;
    logic                                overflow_reg;
    logic                                overflow_next;
    logic [isort_pkg::CAPACITY-1:0]      take;
    logic                                pop;
    logic                                full;

    assign item_ready   = (state_reg == ST_LOAD);
    assign pop          = item_valid && item_ready;
    assign full         = (held_reg == isort_pkg::COUNT_BITS'(isort_pkg::CAPACITY));
    assign strobe       = (state_reg == ST_EMIT);
    assign sorted_value = store_reg[0];
    assign final_result = (held_reg == isort_pkg::COUNT_BITS'(1));
    assign dropped      = overflow_reg;

    // A cell takes a new entry if it holds a larger value or is the first free cell.
    always_comb
    begin
        for (int i = 0; i < isort_pkg::CAPACITY; i++)
        begin
            if (isort_pkg::COUNT_BITS'(i) < held_reg)
            begin
                take[i] = (store_reg[i] > item.value);
            end
            else
            begin
                take[i] = (isort_pkg::COUNT_BITS'(i) == held_reg);
            end
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        held_next     = held_reg;
        overflow_next = overflow_reg;
        for (int i = 0; i < isort_pkg::CAPACITY; i++)
        begin
            store_next[i] = store_reg[i];
        end
        unique case (state_reg)
            ST_LOAD:
            begin
                if (pop)
                begin
                    if (full)
                    begin
                        overflow_next = 1'b1;
                    end
                    else
                    begin
                        held_next = held_reg + 1'b1;
                        for (int i = 0; i < isort_pkg::CAPACITY; i++)
                        begin
                            if (take[i])
                            begin
                                if (i > 0 && take[(i > 0) ? i - 1 : 0])
                                begin
                                    store_next[i] = store_reg[(i > 0) ? i - 1 : 0];
                                end
                                else
                                begin
                                    store_next[i] = item.value;
                                end
                            end
                        end
                    end
                    if (item.batch_end)
                    begin
                        state_next = ST_EMIT;
                    end
                end
            end
            ST_EMIT:
            begin
                // Advance the store toward cell zero, one result per cycle.
                for (int i = 0; i < isort_pkg::CAPACITY - 1; i++)
                begin
                    store_next[i] = store_reg[i + 1];
                end
                held_next = held_reg - 1'b1;
                if (final_result)
                begin
                    overflow_next = 1'b0;
                    state_next    = ST_LOAD;
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_LOAD;
            held_reg     <= '0;
            overflow_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            held_reg     <= held_next;
            overflow_reg <= overflow_next;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < isort_pkg::CAPACITY; i++)
        begin
            store_reg[i] <= store_next[i];
        end
    end

endmodule
